[design/ncrf_pkg.sv]
// ----------------------------------------------------------------------------
// ncrf_pkg
// Shared types and constants for the cubic Newton root finder.
// ----------------------------------------------------------------------------
package ncrf_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ERR_W    = 31;
   localparam int unsigned LIMIT_W  = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_ERROR   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATION_LIMIT = 1'd1;

   localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_DERIV = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd2;

   localparam logic [ERR_W-1:0]   ERR_RESET   = 31'd66;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd64;

   // product magnitudes clamp at 2^62
   localparam logic [63:0] PROD_LIM = 64'h4000_0000_0000_0000;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL1 = 9'b000000010,
      ST_MUL2 = 9'b000000100,
      ST_FD1  = 9'b000001000,
      ST_FD2  = 9'b000010000,
      ST_ZCHK = 9'b000100000,
      ST_DIV  = 9'b001000000,
      ST_UPD  = 9'b010000000,
      ST_CHK  = 9'b100000000
   } state_type;

   function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
      mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

[design/newton_cubic_root_finder.sv]
// ----------------------------------------------------------------------------
// newton_cubic_root_finder
// Newton iteration on f(x) = x^3 - x^2 + 2 in signed fixed point.
// ----------------------------------------------------------------------------
// One item at a time. Each Newton step runs two bit-serial multiplies, the
// add and zero-check states, a restoring divider over a 64+FRAC_BITS-bit
// dividend, and the update and check states. An item takes one step per
// update, plus one when it stops on its first step or on a zero derivative,
// so at most iteration_limit steps (one when the limit is zero), plus
// accepting the item and transferring the result.
module newton_cubic_root_finder #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ncrf_pkg::DATA_W-1:0]     req_start_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ncrf_pkg::DATA_W-1:0]     rsp_root_value,
   output logic        [ncrf_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                                   csr_write,
   input  logic        [ncrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [ncrf_pkg::ERR_W-1:0]      csr_data
);
   import ncrf_pkg::*;

   localparam int unsigned DIV_W  = 64 + FRAC_BITS;
   localparam int unsigned DCNT_W = $clog2(DIV_W);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_W - 1);
   localparam logic signed [63:0] TWO_FX = 64'sd2 <<< FRAC_BITS;

   state_type state_ff, state_in;
   logic signed [31:0] x_ff, x_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        first_ff, first_in;
   logic [30:0] err_ff, err_in;
   logic [7:0]  lim_ff, lim_in;
   logic [62:0] mul_a_ff, mul_a_in;
   logic [31:0] mul_b_ff, mul_b_in;
   logic [63:0] acc_ff, acc_in;
   logic        msat_ff, msat_in;
   logic [4:0]  mcnt_ff, mcnt_in;
   logic [62:0] x2_ff, x2_in;
   logic signed [63:0] x3_ff, x3_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [63:0] f_ff, f_in, d_ff, d_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [63:0] dm_ff, dm_in, rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic        qsat_ff, qsat_in, qneg_ff, qneg_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic        out_valid_ff, out_valid_in;
   logic signed [31:0] root_ff, root_in;
   logic [1:0]  status_ff, status_in;

   logic [63:0] mul_sum, prod, prod_sh;
   logic [64:0] rem2;
   logic        ge;
   logic [32:0] qmag;
   logic signed [33:0] m_val;
   logic signed [34:0] diff;
   logic signed [31:0] x_sat;
   logic        below_err;

   assign req_stall      = (state_ff != ST_IDLE) || out_valid_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_root_value = root_ff;
   assign rsp_status     = status_ff;

   always_comb begin
      mul_sum = {acc_ff[62:0], 1'b0} + (mul_b_ff[31] ? {1'b0, mul_a_ff} : 64'd0);
      prod    = (msat_ff || mul_sum > PROD_LIM) ? PROD_LIM : mul_sum;
      prod_sh = prod >> FRAC_BITS;
      rem2    = {rem_ff, dvd_ff[DIV_W-1]};
      ge      = rem2 >= {1'b0, dm_ff};
      qmag    = qsat_ff ? 33'h1_0000_0000 : {1'b0, q_ff};
      m_val   = qneg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      diff    = 35'(x_ff) - 35'(m_val);
      if (diff > 35'sd2147483647) begin
         x_sat = 32'sh7FFF_FFFF;
      end else if (diff < -35'sd2147483648) begin
         x_sat = 32'sh8000_0000;
      end else begin
         x_sat = diff[31:0];
      end
      below_err = qmag < {2'b00, err_ff};
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; cnt_in = cnt_ff; first_in = first_ff;
      err_in = err_ff; lim_in = lim_ff;
      mul_a_in = mul_a_ff; mul_b_in = mul_b_ff; acc_in = acc_ff;
      msat_in = msat_ff; mcnt_in = mcnt_ff;
      x2_in = x2_ff; x3_in = x3_ff; t1_in = t1_ff; t2_in = t2_ff;
      f_in = f_ff; d_in = d_ff;
      dvd_in = dvd_ff; dm_in = dm_ff; rem_in = rem_ff; q_in = q_ff;
      qsat_in = qsat_ff; qneg_in = qneg_ff; dcnt_in = dcnt_ff;
      out_valid_in = out_valid_ff; root_in = root_ff; status_in = status_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_ALLOWED_ERROR:   err_in = csr_data;
            CSR_ITERATION_LIMIT: lim_in = csr_data[7:0];
            default: ;
         endcase
      end

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               x_in     = req_start_value;
               cnt_in   = 8'd0;
               first_in = 1'b1;
               mul_a_in = {31'd0, mag32(req_start_value)};
               mul_b_in = mag32(req_start_value);
               acc_in   = 64'd0;
               msat_in  = 1'b0;
               mcnt_in  = 5'd0;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1, ST_MUL2: begin
            if (!msat_ff) begin
               acc_in  = mul_sum;
               msat_in = mul_sum > PROD_LIM;
            end
            mul_b_in = {mul_b_ff[30:0], 1'b0};
            mcnt_in  = mcnt_ff + 5'd1;
            if (mcnt_ff == 5'd31) begin
               if (state_ff == ST_MUL1) begin
                  x2_in    = prod_sh[62:0];
                  mul_a_in = prod_sh[62:0];
                  mul_b_in = mag32(x_ff);
                  acc_in   = 64'd0;
                  msat_in  = 1'b0;
                  state_in = ST_MUL2;
               end else begin
                  x3_in    = x_ff[31] ? -$signed(prod_sh) : $signed(prod_sh);
                  state_in = ST_FD1;
               end
            end
         end
         ST_FD1: begin
            t1_in    = x3_ff - $signed({1'b0, x2_ff});
            t2_in    = $signed({1'b0, x2_ff}) + $signed({x2_ff, 1'b0});
            state_in = ST_FD2;
         end
         ST_FD2: begin
            f_in     = t1_ff + TWO_FX;
            d_in     = t2_ff - (64'(x_ff) <<< 1);
            state_in = ST_ZCHK;
         end
         ST_ZCHK: begin
            if (d_ff == 64'sd0) begin
               root_in      = x_ff;
               status_in    = STATUS_ZERO_DERIV;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               dvd_in   = {(f_ff[63] ? 64'(-f_ff) : 64'(f_ff)), FRAC_BITS'(0)};
               dm_in    = d_ff[63] ? 64'(-d_ff) : 64'(d_ff);
               qneg_in  = f_ff[63] ^ d_ff[63];
               rem_in   = 64'd0;
               q_in     = 32'd0;
               qsat_in  = 1'b0;
               dcnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? 64'(rem2 - {1'b0, dm_ff}) : rem2[63:0];
            q_in    = {q_ff[30:0], ge};
            qsat_in = qsat_ff | q_ff[31];
            dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_LAST) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            first_in = 1'b0;
            if (first_ff && below_err) begin
               root_in      = x_ff;
               status_in    = STATUS_CONVERGED;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (first_ff && cnt_ff >= lim_ff) begin
               root_in      = x_ff;
               status_in    = STATUS_LIMIT;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               x_in     = x_sat;
               cnt_in   = cnt_ff + 8'd1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (below_err || cnt_ff >= lim_ff) begin
               root_in      = x_ff;
               status_in    = below_err ? STATUS_CONVERGED : STATUS_LIMIT;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mul_a_in = {31'd0, mag32(x_ff)};
               mul_b_in = mag32(x_ff);
               acc_in   = 64'd0;
               msat_in  = 1'b0;
               mcnt_in  = 5'd0;
               state_in = ST_MUL1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         err_ff       <= ERR_RESET;
         lim_ff       <= LIMIT_RESET;
         x_ff         <= '0;
         cnt_ff       <= '0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         err_ff       <= err_in;
         lim_ff       <= lim_in;
         x_ff         <= x_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      acc_ff   <= acc_in;
      msat_ff  <= msat_in;
      mcnt_ff  <= mcnt_in;
      x2_ff    <= x2_in;
      x3_ff    <= x3_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      f_ff     <= f_in;
      d_ff     <= d_in;
      dvd_ff   <= dvd_in;
      dm_ff    <= dm_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      qsat_ff  <= qsat_in;
      qneg_ff  <= qneg_in;
      dcnt_ff  <= dcnt_in;
      root_ff  <= root_in;
      status_ff <= status_in;
   end

endmodule
